// ===== src/int_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the conversion modules.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// A property that must hold at every clock edge.
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define ITOA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/itoa_pkg.sv =====
package itoa_pkg;

  // Field and datapath widths.
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W     = 4 * BCD_DIGITS;
  localparam int unsigned BITCNT_W  = $clog2(VALUE_W);
  localparam int unsigned DIGCNT_W  = $clog2(BCD_DIGITS + 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // Last shift of the binary-to-BCD conversion.
  localparam logic [BITCNT_W-1:0] BITCNT_LAST = BITCNT_W'(VALUE_W - 1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request and clear the BCD register
    logic conv;        // one double-dabble step
    logic shift_digit; // drop the top BCD digit
    logic sel_sign;    // present the minus sign on the output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;   // this conversion step is the final one
    logic top_zero;    // the top BCD digit is zero
    logic one_left;    // only one digit remains to emit
    logic negative;    // the captured value was negative
  } sts_t;

endpackage

// ===== src/itoa_dp.sv =====
`include "int_to_decimal_ascii_macros.svh"

module itoa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itoa_pkg::cmd_t                cmd_i,
  output itoa_pkg::sts_t                sts_o,
  input  logic [itoa_pkg::VALUE_W-1:0]  value_i,
  output logic [itoa_pkg::CHAR_W-1:0]   char_o,
  output logic                          last_o
);

  logic [itoa_pkg::VALUE_W-1:0]  mag_q, mag_d;
  logic [itoa_pkg::BCD_W-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [itoa_pkg::BITCNT_W-1:0] bitcnt_q, bitcnt_d;
  logic [itoa_pkg::DIGCNT_W-1:0] digcnt_q, digcnt_d;
  logic                          neg_q, neg_d;
  logic [3:0]                    top_digit;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Next values of the working registers.
  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    bitcnt_d = bitcnt_q;
    digcnt_d = digcnt_q;
    neg_d    = neg_q;
    if (cmd_i.load) begin
      neg_d    = value_i[itoa_pkg::VALUE_W-1];
      mag_d    = value_i[itoa_pkg::VALUE_W-1] ?
                 (itoa_pkg::VALUE_W'(0) - value_i) : value_i;
      bcd_d    = '0;
      bitcnt_d = '0;
      digcnt_d = itoa_pkg::DIGCNT_W'(itoa_pkg::BCD_DIGITS);
    end else if (cmd_i.conv) begin
      bcd_d    = {bcd_adj[itoa_pkg::BCD_W-2:0], mag_q[itoa_pkg::VALUE_W-1]};
      mag_d    = {mag_q[itoa_pkg::VALUE_W-2:0], 1'b0};
      bitcnt_d = bitcnt_q + 1'b1;
    end else if (cmd_i.shift_digit) begin
      bcd_d    = {bcd_q[itoa_pkg::BCD_W-5:0], 4'd0};
      digcnt_d = digcnt_q - 1'b1;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q    <= '0;
      bitcnt_q <= '0;
      digcnt_q <= itoa_pkg::DIGCNT_W'(1);
      neg_q    <= 1'b0;
    end else begin
      bcd_q    <= bcd_d;
      bitcnt_q <= bitcnt_d;
      digcnt_q <= digcnt_d;
      neg_q    <= neg_d;
    end
  end

  // The magnitude needs no reset; it is loaded with every request.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  // Status and output character.
  assign top_digit          = bcd_q[itoa_pkg::BCD_W-1 -: 4];
  assign sts_o.conv_last    = (bitcnt_q == itoa_pkg::BITCNT_LAST);
  assign sts_o.top_zero     = (top_digit == 4'd0);
  assign sts_o.one_left     = (digcnt_q == itoa_pkg::DIGCNT_W'(1));
  assign sts_o.negative     = neg_q;
  assign char_o = cmd_i.sel_sign ? itoa_pkg::ASCII_MINUS
                                 : (itoa_pkg::ASCII_ZERO | {4'd0, top_digit});
  assign last_o = !cmd_i.sel_sign && sts_o.one_left;

  // Checks on the datapath.
  `ITOA_ASSERT(a_digcnt_nonzero, digcnt_q != '0, "digit count reached zero")
  `ITOA_ASSERT(a_top_digit_bcd, top_digit <= 4'd9, "top digit is not a decimal digit")
  `ITOA_ASSERT_NEXT(a_load_clears, cmd_i.load,
                    bcd_q == '0 && bitcnt_q == '0, "load did not clear the converter")

endmodule

// ===== src/itoa_ctrl.sv =====
`include "int_to_decimal_ascii_macros.svh"

module itoa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output itoa_pkg::cmd_t  cmd_o,
  input  itoa_pkg::sts_t  sts_i
);

  itoa_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        if (sts_i.conv_last) begin
          state_d = itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SKIP: begin
        if (!sts_i.top_zero || sts_i.one_left) begin
          state_d = sts_i.negative ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_ready_i) begin
          state_d = itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_DIGIT: begin
        if (out_ready_i && sts_i.one_left) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      itoa_pkg::ST_CONV: begin
        cmd_o.conv = 1'b1;
      end
      itoa_pkg::ST_SKIP: begin
        cmd_o.shift_digit = sts_i.top_zero && !sts_i.one_left;
      end
      itoa_pkg::ST_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
      end
      itoa_pkg::ST_DIGIT: begin
        // The final digit stays in place; the next load clears it.
        out_valid_o       = 1'b1;
        cmd_o.shift_digit = out_ready_i && !sts_i.one_left;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks on the controller.
  `ITOA_ASSERT(a_one_at_a_time, !(in_ready_o && out_valid_o),
               "request taken while a character is pending")
  `ITOA_ASSERT_NEXT(a_conv_to_skip, state_q == itoa_pkg::ST_CONV && sts_i.conv_last,
                    state_q == itoa_pkg::ST_SKIP, "conversion did not end on time")
  `ITOA_ASSERT_IMPL(a_sign_if_negative, state_q == itoa_pkg::ST_SIGN,
                    sts_i.negative, "minus sign for a non-negative value")

endmodule

// ===== src/int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text.
// Input channel s_axis: one request per 32-bit two's complement value.
// Output channel m_axis: the decimal text, one character per transfer, most
// significant first, with a leading '-' for negative values and no leading
// zeros; tlast marks the final character of each number (1 to 11 characters).
// The block works on one request at a time and takes a new one only after the
// last character of the previous one has been taken.
// After the accept edge, the bit-serial binary-to-BCD shifter runs one step per
// input bit, then leading zero digits are dropped one per cycle, a decision
// step follows, and the characters follow one per cycle while the receiver
// keeps tready high; the next request is taken in the idle state that follows.
// When the receiver holds tready low, the current character and tlast hold
// steady until taken. Reset (rst_ni low) returns the block to idle, ready for
// a request; any partially emitted text is abandoned.
module int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] text_char
  output logic        m_axis_tlast_o    // last_char
);

  itoa_pkg::cmd_t cmd;
  itoa_pkg::sts_t sts;

  // Sequencing of conversion, zero skipping and character output.
  itoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Magnitude, BCD shifter and character formation.
  itoa_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .value_i (s_axis_tdata_i),
    .char_o  (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

endmodule

// ===== dv/tb_int_to_decimal_ascii.sv =====
module tb_int_to_decimal_ascii;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RADIX       = 10;
  localparam int unsigned MAX_GAP     = 19;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_VALUES = 239;

  // One character of the expected text.
  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] text_char;
    logic                        last_char;
  } char_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [itoa_pkg::VALUE_W-1:0] s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [itoa_pkg::CHAR_W-1:0]  m_tdata;
  logic                         m_tlast;

  logic [itoa_pkg::VALUE_W-1:0] pending_values[$];
  char_beat_t                   expected_text[$];

  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  logic        hold_rx = 1'b0;
  int unsigned accepted_cnt = 0;
  int unsigned negative_cnt = 0;
  int unsigned longest_cnt = 0;
  int unsigned chars_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  int_to_decimal_ascii dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  // Clock and a single reset pulse at the start.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Spell a value as decimal text and queue its characters, sign first.
  function automatic void spell_decimal(input logic [itoa_pkg::VALUE_W-1:0] value);
    logic [itoa_pkg::VALUE_W-1:0] mag;
    logic [3:0]                   digit_buf[10];
    int                           ndig;
    char_beat_t                   beat;
    begin
      ndig = 0;
      mag  = value[itoa_pkg::VALUE_W-1] ? ~value + 1'b1 : value;
      do begin
        digit_buf[ndig] = 4'(mag % RADIX);
        mag  = mag / RADIX;
        ndig = ndig + 1;
      end while (mag != 0);
      if (value[itoa_pkg::VALUE_W-1]) begin
        beat.text_char = itoa_pkg::ASCII_MINUS;
        beat.last_char = 1'b0;
        expected_text.push_back(beat);
        negative_cnt++;
      end
      if (ndig + int'(value[itoa_pkg::VALUE_W-1]) == 11) longest_cnt++;
      for (int k = ndig - 1; k >= 0; k--) begin
        beat.text_char = itoa_pkg::CHAR_W'(itoa_pkg::ASCII_ZERO + digit_buf[k]);
        beat.last_char = (k == 0);
        expected_text.push_back(beat);
      end
    end
  endfunction

  // Request driver: offers queued values with random gaps, with back-to-back stretches.
  always @(posedge clk_i) begin
    int unsigned gap_next;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      gap_next = tx_wait;
      if (s_tvalid && s_tready) begin
        spell_decimal(s_tdata);
        accepted_cnt++;
        gap_next = ((accepted_cnt % 64) >= 44) ? 0 : $urandom_range(0, MAX_GAP);
      end else if (!s_tvalid && gap_next > 0) begin
        gap_next--;
      end
      if ((!s_tvalid || s_tready) && gap_next == 0 && pending_values.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_values.pop_front();
      end else if (s_tvalid && s_tready) begin
        s_tvalid <= 1'b0;
      end
      tx_wait <= gap_next;
    end
  end

  // Character monitor: checks every accepted character and paces tready.
  always @(posedge clk_i) begin
    char_beat_t  want;
    int unsigned wait_next;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      wait_next = rx_wait;
      if (m_tvalid && m_tready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] character 0x%02h last=%0b arrived with no text pending",
                     $realtime, m_tdata, m_tlast);
        end else begin
          want = expected_text.pop_front();
          if (m_tdata !== want.text_char || m_tlast !== want.last_char) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("[%0t] character: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       $realtime, want.text_char, want.last_char, m_tdata, m_tlast);
          end
        end
        wait_next = ((chars_seen % 300) >= 220) ? 0 : $urandom_range(0, MAX_GAP);
      end else if (wait_next > 0) begin
        wait_next--;
      end
      rx_wait  <= wait_next;
      m_tready <= !hold_rx && wait_next == 0;
    end
  end

  // Long receiver hold-off so the block stalls on a character and back-pressures requests.
  initial begin
    while (accepted_cnt < 40) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Run did not drain within %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus: directed corner values, then random values by digit count, raw, near powers of ten and at corners.
  initial begin
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned p10;
    int unsigned     ndig;
    int unsigned     pick;
    logic [itoa_pkg::VALUE_W-1:0] v;

    pending_values = {32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                      32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                      32'd1000000000, 32'd999999999, -32'sd999999999,
                      32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd7,
                      -32'sd1000000000, 32'd4000000000, 32'd2000000000};

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // Uniform magnitude within a chosen number of digits.
        ndig = $urandom_range(1, 10);
        p10  = 1;
        for (int k = 1; k < ndig; k++) p10 = p10 * RADIX;
        lo = (ndig == 1) ? 0 : p10;
        hi = p10 * RADIX - 1;
        if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
        v = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end else if (pick <= 7) begin
        v = $urandom;
      end else if (pick == 8) begin
        // Around a power of ten, where the digit count changes.
        p10 = 1;
        ndig = $urandom_range(0, 9);
        for (int k = 0; k < ndig; k++) p10 = p10 * RADIX;
        v = 32'(p10) + 32'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end else begin
        case ($urandom_range(0, 3))
          0:       v = 32'd0;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      pending_values.push_back(v);
    end

    // Let everything be accepted and every character drain.
    while (pending_values.size() != 0 || s_tvalid) @(posedge clk_i);
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d values (%0d negative, %0d of full 11-character length)",
             accepted_cnt, negative_cnt, longest_cnt);
    $display("Checked %0d characters with random gaps on both sides and one %0d-cycle hold-off",
             chars_seen, HOLD_CYCLES);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
